FILE: src/u8n1_pkg.sv
// shared types and constants for the 8n1 uart transceiver
package u8n1_pkg;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 1'b1;

    localparam logic [7:0] BIT_TICKS_RESET = 8'd104;
    localparam logic [7:0] START_OFFSET_RESET = 8'd48;
    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [3:0] FRAME_BITS = 4'd10;
    localparam logic [2:0] LAST_DATA_BIT = 3'd7;

    typedef enum logic [3:0] {
        RX_WAIT_IDLE   = 4'b0001,
        RX_WAIT_EDGE   = 4'b0010,
        RX_WAIT_OFFSET = 4'b0100,
        RX_SAMPLING    = 4'b1000
    } rx_phase_t;

    typedef struct packed {
        logic line;
        logic busy;
    } tx_status_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       eom;
    } rx_result_t;

endpackage

FILE: src/uart_8n1_transceiver_top.sv
// top level of the timer-driven 8n1 uart transceiver
//
// Each input transfer is one tick of the bit timer: the sampled receive
// level, a send request and the byte to send. Each tick gives exactly one
// output transfer with the transmit line level, the busy flag and, on the
// tick that completes a received byte, rx_valid, the byte and an
// end-of-message flag for newline.
// A tick passes through an input register and then a result register before
// its output transfer is offered, and one tick per cycle is sustained as
// long as out_ready stays high.
// When the output side stalls, the result register holds its transfer, the
// input register holds the next tick, and in_ready drops until the result
// is taken; the uart timers advance only on ticks, never on idle cycles.
// The config channel writes bit_ticks (index 0) and start_offset_ticks
// (index 1) and is always ready; the user must write it only while no tick
// is in flight, not enforced by the block. A value of 0 counts as 256 ticks.
// Reset loads 104 and 48, clears both pipeline stages, idles the
// transmitter and sets the receiver to wait for an idle-high line.
module uart_8n1_transceiver_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [u8n1_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           rx_level,
    input  logic                           tx_valid,
    input  logic [7:0]                     tx_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           tx_line,
    output logic                           tx_busy,
    output logic                           rx_valid,
    output logic [7:0]                     rx_byte,
    output logic                           rx_end_of_message
);

    logic [7:0] bit_ticks_reg;
    logic [7:0] start_offset_reg;

    logic       in_valid_reg;
    logic       rx_level_reg;
    logic       tx_req_reg;
    logic [7:0] tx_byte_reg;

    logic       out_valid_reg;
    logic       tx_line_reg;
    logic       tx_busy_reg;
    logic       rx_valid_reg;
    logic [7:0] rx_byte_reg;
    logic       rx_eom_reg;

    logic       step;
    logic       in_take;

    u8n1_pkg::tx_status_t tx_status;
    u8n1_pkg::rx_result_t rx_result;

    // pipeline advance control
    assign step      = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || step;
    assign in_take   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_ticks_reg    <= u8n1_pkg::BIT_TICKS_RESET;
            start_offset_reg <= u8n1_pkg::START_OFFSET_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                u8n1_pkg::CFG_BIT_TICKS:    bit_ticks_reg    <= cfg_data;
                u8n1_pkg::CFG_START_OFFSET: start_offset_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            rx_level_reg <= rx_level;
            tx_req_reg   <= tx_valid;
            tx_byte_reg  <= tx_byte;
        end
    end

    u8n1_tx u_tx (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .req       (tx_req_reg),
        .data      (tx_byte_reg),
        .bit_ticks (bit_ticks_reg),
        .status    (tx_status)
    );

    u8n1_rx u_rx (
        .clk                (clk),
        .rst_n              (rst_n),
        .step               (step),
        .level              (rx_level_reg),
        .bit_ticks          (bit_ticks_reg),
        .start_offset_ticks (start_offset_reg),
        .result             (rx_result)
    );

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            tx_line_reg  <= tx_status.line;
            tx_busy_reg  <= tx_status.busy;
            rx_valid_reg <= rx_result.valid;
            rx_byte_reg  <= rx_result.data;
            rx_eom_reg   <= rx_result.eom;
        end
    end

    assign out_valid         = out_valid_reg;
    assign tx_line           = tx_line_reg;
    assign tx_busy           = tx_busy_reg;
    assign rx_valid          = rx_valid_reg;
    assign rx_byte           = rx_byte_reg;
    assign rx_end_of_message = rx_eom_reg;

    // a held tick is not lost while the result stage is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step |=> in_valid_reg)
        else $error("input register dropped a tick");

    // end of message only with a received newline
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rx_end_of_message |->
            rx_valid && (rx_byte == u8n1_pkg::NEWLINE_CODE))
        else $error("end of message without newline byte");

    // idle transmitter holds the line high
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tx_busy |-> tx_line)
        else $error("transmit line low while idle");

    // a tick enters the timers only when the result register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("tick stepped without a result");

endmodule

FILE: src/u8n1_tx.sv
// transmit frame shifter and bit timer
module u8n1_tx (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 req,
    input  logic [7:0]           data,
    input  logic [7:0]           bit_ticks,
    output u8n1_pkg::tx_status_t status
);

    logic [9:0] frame_reg;
    logic [9:0] frame_next;
    logic [3:0] bits_left_reg;
    logic [3:0] bits_left_next;
    logic [7:0] timer_reg;
    logic [7:0] timer_next;

    // next frame state for one tick
    always_comb
    begin
        frame_next     = frame_reg;
        bits_left_next = bits_left_reg;
        timer_next     = timer_reg;
        if (bits_left_reg == 4'd0)
        begin
            if (req)
            begin
                frame_next     = {1'b1, data, 1'b0};
                bits_left_next = u8n1_pkg::FRAME_BITS;
                timer_next     = 8'd0;
            end
        end
        else if (timer_reg == bit_ticks - 8'd1)
        begin
            frame_next     = {1'b0, frame_reg[9:1]};
            bits_left_next = bits_left_reg - 4'd1;
            timer_next     = 8'd0;
        end
        else
        begin
            timer_next = timer_reg + 8'd1;
        end
    end

    // line level after the tick
    assign status.busy = (bits_left_next != 4'd0);
    assign status.line = status.busy ? frame_next[0] : 1'b1;

    // state update once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg     <= '0;
            bits_left_reg <= '0;
            timer_reg     <= '0;
        end
        else if (step)
        begin
            frame_reg     <= frame_next;
            bits_left_reg <= bits_left_next;
            timer_reg     <= timer_next;
        end
    end

endmodule

FILE: src/u8n1_rx.sv
// receive phase sequencer, sample timer and shift register
module u8n1_rx (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 level,
    input  logic [7:0]           bit_ticks,
    input  logic [7:0]           start_offset_ticks,
    output u8n1_pkg::rx_result_t result
);

    u8n1_pkg::rx_phase_t phase_reg;
    u8n1_pkg::rx_phase_t phase_next;
    logic [7:0] timer_reg;
    logic [7:0] timer_next;
    logic [7:0] shift_reg;
    logic [7:0] shift_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;

    // next receiver state for one tick
    always_comb
    begin
        phase_next   = phase_reg;
        timer_next   = timer_reg;
        shift_next   = shift_reg;
        count_next   = count_reg;
        result.valid = 1'b0;
        result.data  = 8'd0;
        case (phase_reg)
            u8n1_pkg::RX_WAIT_IDLE:
            begin
                if (level)
                    phase_next = u8n1_pkg::RX_WAIT_EDGE;
            end
            u8n1_pkg::RX_WAIT_EDGE:
            begin
                if (!level)
                begin
                    phase_next = u8n1_pkg::RX_WAIT_OFFSET;
                    timer_next = 8'd0;
                end
            end
            u8n1_pkg::RX_WAIT_OFFSET:
            begin
                if (timer_reg == start_offset_ticks - 8'd1)
                begin
                    phase_next = u8n1_pkg::RX_SAMPLING;
                    timer_next = 8'd0;
                    shift_next = 8'd0;
                    count_next = 3'd0;
                end
                else
                begin
                    timer_next = timer_reg + 8'd1;
                end
            end
            u8n1_pkg::RX_SAMPLING:
            begin
                if (timer_reg == bit_ticks - 8'd1)
                begin
                    timer_next = 8'd0;
                    shift_next = {level, shift_reg[7:1]};
                    count_next = count_reg + 3'd1;
                    if (count_reg == u8n1_pkg::LAST_DATA_BIT)
                    begin
                        result.valid = 1'b1;
                        result.data  = shift_next;
                        count_next   = 3'd0;
                        phase_next   = u8n1_pkg::RX_WAIT_IDLE;
                    end
                end
                else
                begin
                    timer_next = timer_reg + 8'd1;
                end
            end
            default:
            begin
                phase_next = u8n1_pkg::RX_WAIT_IDLE;
            end
        endcase
        // end of message flag
        result.eom = result.valid && (result.data == u8n1_pkg::NEWLINE_CODE);
    end

    // state update once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= u8n1_pkg::RX_WAIT_IDLE;
            timer_reg <= '0;
            shift_reg <= '0;
            count_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            shift_reg <= shift_next;
            count_reg <= count_next;
        end
    end

endmodule
